### design/m6800_instruction_predecoder_core_assert.svh
// assertion macros used by the predecoder rtl
`ifndef M6800_INSTRUCTION_PREDECODER_CORE_ASSERT_SVH
`define M6800_INSTRUCTION_PREDECODER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define M6PD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked later than the antecedent, outside reset
`define M6PD_ASSERT_LAT2(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

### design/m6pd_pkg.sv
// types, codes and opcode tables for the 6800 instruction predecoder
package m6pd_pkg;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  opcode;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  length;
    logic [6:0]  mnemonic;
    logic [2:0]  mode;
    logic [1:0]  accumulator;
    logic [15:0] operand_value;
    logic        target_valid;
    logic [15:0] target;
    logic        is_call;
    logic        ref_valid;
  } out_item_t;

  // addressing modes
  localparam logic [2:0] MODE_INH  = 3'd0;
  localparam logic [2:0] MODE_IMM8 = 3'd1;
  localparam logic [2:0] MODE_IMM16 = 3'd2;
  localparam logic [2:0] MODE_DIR  = 3'd3;
  localparam logic [2:0] MODE_IDX  = 3'd4;
  localparam logic [2:0] MODE_EXT  = 3'd5;
  localparam logic [2:0] MODE_REL  = 3'd6;
  localparam logic [2:0] MODE_SWI  = 3'd7;

  // accumulator select
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_A    = 2'd1;
  localparam logic [1:0] ACC_B    = 2'd2;

  // instruction lengths
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // mnemonic codes used by name
  localparam logic [6:0] MN_NONE = 7'd0;
  localparam logic [6:0] MN_BSR  = 7'd21;
  localparam logic [6:0] MN_CPX  = 7'd31;
  localparam logic [6:0] MN_JMP  = 7'd40;
  localparam logic [6:0] MN_JSR  = 7'd41;
  localparam logic [6:0] MN_LDS  = 7'd43;
  localparam logic [6:0] MN_LDX  = 7'd44;
  localparam logic [6:0] MN_STS  = 7'd63;
  localparam logic [6:0] MN_STX  = 7'd64;

  // opcodes with special handling
  localparam logic [7:0] OP_BSR     = 8'h8D;
  localparam logic [7:0] OP_JSR_IDX = 8'hAD;
  localparam logic [7:0] OP_JSR_EXT = 8'hBD;
  localparam logic [7:0] OP_SWI     = 8'h3F;
  localparam logic [7:0] OP_BRN     = 8'h21;
  localparam logic [3:0] HI_BRANCH  = 4'h2;

  // low nibbles of the upper half
  localparam logic [3:0] LO_CPX = 4'hC;
  localparam logic [3:0] LO_JSR = 4'hD;
  localparam logic [3:0] LO_LDS = 4'hE;

  // two-operand group, low nibble 0..b
  function automatic logic [6:0] acc_op(input logic [3:0] lo);
    logic [6:0] mn;
    unique case (lo)
      4'h0:    mn = 7'd65;
      4'h1:    mn = 7'd29;
      4'h2:    mn = 7'd58;
      4'h4:    mn = 7'd4;
      4'h5:    mn = 7'd13;
      4'h6:    mn = 7'd42;
      4'h7:    mn = 7'd62;
      4'h8:    mn = 7'd36;
      4'h9:    mn = 7'd2;
      4'hA:    mn = 7'd48;
      4'hB:    mn = 7'd3;
      default: mn = MN_NONE;
    endcase
    return mn;
  endfunction

  // unary group 0x40..0x7f
  function automatic logic [6:0] unary_op(input logic [3:0] lo);
    logic [6:0] mn;
    unique case (lo)
      4'h0:    mn = 7'd46;
      4'h3:    mn = 7'd30;
      4'h4:    mn = 7'd45;
      4'h6:    mn = 7'd54;
      4'h7:    mn = 7'd6;
      4'h8:    mn = 7'd5;
      4'h9:    mn = 7'd53;
      4'hA:    mn = 7'd33;
      4'hC:    mn = 7'd37;
      4'hD:    mn = 7'd71;
      4'hE:    mn = MN_JMP;
      4'hF:    mn = 7'd27;
      default: mn = MN_NONE;
    endcase
    return mn;
  endfunction

  // opcodes 0x00..0x3f
  function automatic logic [6:0] low_op(input logic [5:0] idx);
    logic [6:0] mn;
    unique case (idx)
      6'h01:   mn = 7'd47;
      6'h06:   mn = 7'd68;
      6'h07:   mn = 7'd70;
      6'h08:   mn = 7'd39;
      6'h09:   mn = 7'd35;
      6'h0A:   mn = 7'd28;
      6'h0B:   mn = 7'd61;
      6'h0C:   mn = 7'd25;
      6'h0D:   mn = 7'd59;
      6'h0E:   mn = 7'd26;
      6'h0F:   mn = 7'd60;
      6'h10:   mn = 7'd57;
      6'h11:   mn = 7'd24;
      6'h16:   mn = 7'd67;
      6'h17:   mn = 7'd69;
      6'h19:   mn = 7'd32;
      6'h1B:   mn = 7'd1;
      6'h20:   mn = 7'd20;
      6'h22:   mn = 7'd12;
      6'h23:   mn = 7'd15;
      6'h24:   mn = 7'd7;
      6'h25:   mn = 7'd8;
      6'h26:   mn = 7'd18;
      6'h27:   mn = 7'd9;
      6'h28:   mn = 7'd22;
      6'h29:   mn = 7'd23;
      6'h2A:   mn = 7'd19;
      6'h2B:   mn = 7'd17;
      6'h2C:   mn = 7'd10;
      6'h2D:   mn = 7'd16;
      6'h2E:   mn = 7'd11;
      6'h2F:   mn = 7'd14;
      6'h30:   mn = 7'd72;
      6'h31:   mn = 7'd38;
      6'h32:   mn = 7'd51;
      6'h33:   mn = 7'd52;
      6'h34:   mn = 7'd34;
      6'h35:   mn = 7'd73;
      6'h36:   mn = 7'd49;
      6'h37:   mn = 7'd50;
      6'h39:   mn = 7'd56;
      6'h3B:   mn = 7'd55;
      6'h3E:   mn = 7'd74;
      6'h3F:   mn = 7'd66;
      default: mn = MN_NONE;
    endcase
    return mn;
  endfunction

endpackage

### design/m6800_instruction_predecoder_core.sv
// 6800 instruction predecoder: input register, decode, result register
//
// Usage:
//   Present pc, opcode and the two following bytes on in_item and raise
//   start; the item transfers at the rising edge where start is high and
//   busy is low. busy is always low, so one instruction can transfer on
//   every cycle.
//   The decoded instruction appears on out_item with out_strobe high for
//   exactly one cycle, after it has passed the input register and then
//   the decode into the result register.
//   Throughput is one instruction per cycle, set by the single decode
//   stage between the two registers.
//   The receiver cannot stall; it must take out_item while out_strobe is
//   high.
//   rst_n is synchronous and active low; it drops any instruction in
//   flight and holds out_strobe low.
//   The block keeps no state between instructions.
module m6800_instruction_predecoder_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  m6pd_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output m6pd_pkg::out_item_t out_item
);
  import m6pd_pkg::*;

  `include "m6800_instruction_predecoder_core_assert.svh"

  in_item_t  in_item_r;
  logic      in_valid_r;
  logic      in_valid_nxt;
  out_item_t out_item_r;
  out_item_t dec;
  logic      out_strobe_r;

  assign busy         = 1'b0;
  assign in_valid_nxt = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      in_valid_r   <= in_valid_nxt;
      out_strobe_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_nxt) begin
      in_item_r <= in_item;
    end
    if (in_valid_r) begin
      out_item_r <= dec;
    end
  end

  m6pd_decode u_decode (
    .item (in_item_r),
    .dec  (dec)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  `M6PD_ASSERT_LAT2(a_fixed_latency, start && !busy, out_strobe,
    "accepted instruction did not produce a result two cycles later")
  `M6PD_ASSERT_NOW(a_call_mnemonic, out_strobe && out_item.is_call,
    out_item.mnemonic == MN_BSR || out_item.mnemonic == MN_JSR,
    "call flag set on a mnemonic other than bsr or jsr")
  `M6PD_ASSERT_NOW(a_target_mode, out_strobe && out_item.target_valid,
    out_item.mode == MODE_REL || out_item.mode == MODE_EXT,
    "target given for a mode that cannot carry one")
  `M6PD_ASSERT_NOW(a_inherent_shape, out_strobe && out_item.mode == MODE_INH,
    out_item.length == LEN_ONE && out_item.operand_value == 16'd0,
    "inherent instruction with operand bytes")

endmodule

### design/m6pd_decode.sv
// combinational decode of one 6800 instruction
module m6pd_decode (
  input  m6pd_pkg::in_item_t  item,
  output m6pd_pkg::out_item_t dec
);
  import m6pd_pkg::*;

  logic [7:0]  op;
  logic [3:0]  lo;
  logic [1:0]  grp;
  logic [15:0] word;
  logic [15:0] rel;

  assign op   = item.opcode;
  assign lo   = op[3:0];
  assign grp  = op[5:4];
  assign word = {item.byte_one, item.byte_two};
  // pc after a two-byte branch plus sign-extended offset, wraps at 16 bits
  assign rel  = item.pc + 16'd2 + {{8{item.byte_one[7]}}, item.byte_one};

  always_comb begin
    dec               = '0;
    dec.length        = LEN_ONE;
    dec.mnemonic      = MN_NONE;
    dec.mode          = MODE_INH;
    dec.accumulator   = ACC_NONE;
    if (op[7]) begin
      unique case (grp)
        2'd0: begin
          if (lo < LO_CPX || op == OP_BSR) begin
            dec.length        = LEN_TWO;
            dec.mode          = MODE_IMM8;
            dec.operand_value = {8'd0, item.byte_one};
          end else begin
            dec.length        = LEN_THREE;
            dec.mode          = MODE_IMM16;
            dec.operand_value = word;
            dec.ref_valid     = 1'b1;
          end
        end
        2'd1: begin
          dec.length        = LEN_TWO;
          dec.mode          = MODE_DIR;
          dec.operand_value = {8'd0, item.byte_one};
          dec.ref_valid     = 1'b1;
        end
        2'd2: begin
          dec.length        = LEN_TWO;
          dec.mode          = MODE_IDX;
          dec.operand_value = {8'd0, item.byte_one};
        end
        default: begin
          dec.length        = LEN_THREE;
          dec.mode          = MODE_EXT;
          dec.operand_value = word;
          dec.ref_valid     = 1'b1;
        end
      endcase
      priority if (lo < LO_CPX) begin
        dec.accumulator = op[6] ? ACC_B : ACC_A;
        dec.mnemonic    = acc_op(lo);
      end else if (lo == LO_CPX) begin
        dec.mnemonic = op[6] ? MN_NONE : MN_CPX;
      end else if (lo == LO_JSR) begin
        if (op == OP_BSR) begin
          dec.mnemonic     = MN_BSR;
          dec.mode         = MODE_REL;
          dec.is_call      = 1'b1;
          dec.target_valid = 1'b1;
          dec.target       = rel;
          dec.ref_valid    = 1'b1;
        end else if (op == OP_JSR_IDX) begin
          // target depends on x, so none is given
          dec.mnemonic = MN_JSR;
          dec.is_call  = 1'b1;
        end else if (op == OP_JSR_EXT) begin
          dec.mnemonic     = MN_JSR;
          dec.is_call      = 1'b1;
          dec.target_valid = 1'b1;
          dec.target       = word;
        end
      end else if (lo == LO_LDS) begin
        dec.mnemonic = op[6] ? MN_LDX : MN_LDS;
      end else begin
        dec.mnemonic = op[6] ? MN_STX : MN_STS;
      end
    end else if (op[6]) begin
      dec.mnemonic = unary_op(lo);
      unique case (grp)
        2'd0: dec.accumulator = ACC_A;
        2'd1: dec.accumulator = ACC_B;
        2'd2: begin
          dec.length        = LEN_TWO;
          dec.mode          = MODE_IDX;
          dec.operand_value = {8'd0, item.byte_one};
        end
        default: begin
          dec.length        = LEN_THREE;
          dec.mode          = MODE_EXT;
          dec.operand_value = word;
          dec.ref_valid     = 1'b1;
          if (dec.mnemonic == MN_JMP) begin
            dec.target_valid = 1'b1;
            dec.target       = word;
          end
        end
      endcase
    end else begin
      dec.mnemonic = low_op(op[5:0]);
      if (op[7:4] == HI_BRANCH && op != OP_BRN) begin
        dec.length        = LEN_TWO;
        dec.mode          = MODE_REL;
        dec.operand_value = {8'd0, item.byte_one};
        dec.target_valid  = 1'b1;
        dec.target        = rel;
        dec.ref_valid     = 1'b1;
      end else if (op == OP_SWI) begin
        dec.length        = LEN_TWO;
        dec.mode          = MODE_SWI;
        dec.operand_value = {8'd0, item.byte_one};
      end
    end
  end

endmodule
